/* hw/rtl/trsd_pkg.sv */
package trsd_pkg;

    // Letter and field widths are fixed by the stream format.
    localparam int SYM_W   = 5;
    localparam int MODE_W  = 2;
    localparam int SEL_W   = 2;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Item kinds carried on tuser.
    localparam logic [MODE_W-1:0] MODE_DECIPHER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART  = 2'd2;

    // Rotor select codes for wiring writes.
    localparam logic [SEL_W-1:0] ROTOR_FAST   = 2'd0;
    localparam logic [SEL_W-1:0] ROTOR_MIDDLE = 2'd1;
    localparam logic [SEL_W-1:0] ROTOR_SLOW   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_FAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SLOW   = 2'd2;

    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] idx;
        logic [SYM_W-1:0] value;
    } t_rotor_wr;

    typedef struct packed {
        logic step;
        logic restart;
    } t_odo_ctl;

endpackage

/* hw/rtl/trsd_rotor.sv */
module trsd_rotor
    import trsd_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic             i_clk,
    input  t_rotor_wr        i_wr,
    input  logic [SYM_W-1:0] i_letter,
    input  logic [SYM_W-1:0] i_pos,
    output logic [SYM_W-1:0] o_letter
);

    localparam int IDX_W    = $clog2(ALPHABET_SIZE);
    localparam int SUM_W    = SYM_W + 1;
    localparam int MOD_SPAN = 1 << SUM_W;

    logic [SYM_W-1:0] mod_tab [MOD_SPAN];
    logic [SYM_W-1:0] r_wiring [ALPHABET_SIZE];
    logic [SUM_W-1:0] in_sum;
    logic [SYM_W-1:0] in_idx;
    logic [SYM_W-1:0] looked;
    logic [SUM_W-1:0] out_sum;

    // Constant reduction table for any sum of two letters.
    for (genvar g = 0; g < MOD_SPAN; g++) begin : g_mod
        assign mod_tab[g] = SYM_W'(g % ALPHABET_SIZE);
    end

    // Wiring entries have no reset; writes past the alphabet are dropped.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && ({1'b0, i_wr.idx} < SUM_W'(ALPHABET_SIZE))) begin
            r_wiring[i_wr.idx[IDX_W-1:0]] <= i_wr.value;
        end
    end

    always_comb begin
        in_sum   = SUM_W'(i_letter) + SUM_W'(i_pos);
        in_idx   = mod_tab[in_sum];
        looked   = r_wiring[in_idx[IDX_W-1:0]];
        out_sum  = SUM_W'(looked) + SUM_W'(ALPHABET_SIZE) - SUM_W'(i_pos);
        o_letter = mod_tab[out_sum];
    end

endmodule

/* hw/rtl/trsd_odometer.sv */
module trsd_odometer
    import trsd_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_odo_ctl         i_ctl,
    input  logic [CFG_W-1:0] i_start_fast,
    input  logic [CFG_W-1:0] i_start_middle,
    input  logic [CFG_W-1:0] i_start_slow,
    output logic [SYM_W-1:0] o_fast,
    output logic [SYM_W-1:0] o_middle,
    output logic [SYM_W-1:0] o_slow
);

    localparam int START_SPAN = 1 << CFG_W;
    localparam int CMP_W      = SYM_W + 1;
    localparam logic [SYM_W-1:0] LAST = SYM_W'(ALPHABET_SIZE - 1);

    logic [SYM_W-1:0] start_tab [START_SPAN];
    logic [SYM_W-1:0] r_fast, r_middle, r_slow;
    logic [SYM_W-1:0] n_fast, n_middle, n_slow;

    for (genvar g = 0; g < START_SPAN; g++) begin : g_start
        assign start_tab[g] = SYM_W'(g % ALPHABET_SIZE);
    end

    always_comb begin
        n_fast   = r_fast;
        n_middle = r_middle;
        n_slow   = r_slow;
        if (i_ctl.restart) begin
            n_fast   = start_tab[i_start_fast];
            n_middle = start_tab[i_start_middle];
            n_slow   = start_tab[i_start_slow];
        end else if (i_ctl.step) begin
            // Odometer carry: each rotor moves when the one below wraps.
            if (r_fast == LAST) begin
                n_fast = '0;
                if (r_middle == LAST) begin
                    n_middle = '0;
                    n_slow   = (r_slow == LAST) ? '0 : r_slow + 1'b1;
                end else begin
                    n_middle = r_middle + 1'b1;
                end
            end else begin
                n_fast = r_fast + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast   <= '0;
            r_middle <= '0;
            r_slow   <= '0;
        end else begin
            r_fast   <= n_fast;
            r_middle <= n_middle;
            r_slow   <= n_slow;
        end
    end

    assign o_fast   = r_fast;
    assign o_middle = r_middle;
    assign o_slow   = r_slow;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_fast} < CMP_W'(ALPHABET_SIZE)) && ({1'b0, r_middle} < CMP_W'(ALPHABET_SIZE))
        && ({1'b0, r_slow} < CMP_W'(ALPHABET_SIZE)))
        else $error("rotor position outside the alphabet");

    a_fast_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && !i_ctl.restart && r_fast == LAST) |=> (r_fast == '0))
        else $error("fast rotor did not wrap");

    a_middle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctl.step && !i_ctl.restart) |=> $stable(r_middle) && $stable(r_slow))
        else $error("rotor moved without a step or restart");

endmodule

/* hw/rtl/three_rotor_substitution_decrypt_unit.sv */
// Three-rotor substitution decipher.
// Input stream: one word per item. tuser holds the item kind: decipher a
// letter, write one wiring entry of a rotor, or restart the rotor positions
// from the start registers. Only a decipher word produces an output word.
// The three wiring tables must be loaded before letters that use them are
// deciphered; their contents are undefined after reset.
// Configuration: the start positions are written through the write port; the
// user must write them only while the stream is idle, and the block itself
// leaves this unchecked. They take effect at the next restart word. A word is
// captured in the input register, passes the three rotors combinationally, and
// its result is captured in the output register, which drives o_m_tvalid.
// Throughput: one word per cycle while the receiver does not stall. The cycle
// is set by the chain of three rotor passes (add, reduce, table read, subtract,
// reduce) between the input register and the output register.
// Reset clears the rotor positions, start registers and both valid flags.
// When the receiver stalls, the output word holds and the input register
// still takes one more word; non-decipher words keep draining meanwhile.
module three_rotor_substitution_decrypt_unit
    import trsd_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [4:0] symbol, [6:5] rotor_select, [11:7] entry_index, [16:12] entry_value
    input  logic [23:0]          i_s_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]    i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [4:0] plain_symbol
    output logic [7:0]           o_m_tdata
);

    logic [CFG_W-1:0]  r_start_fast, r_start_middle, r_start_slow;
    logic              r_in_valid;
    logic [MODE_W-1:0] r_in_mode;
    logic [SYM_W-1:0]  r_in_symbol;
    logic [SEL_W-1:0]  r_in_sel;
    logic [SYM_W-1:0]  r_in_idx;
    logic [SYM_W-1:0]  r_in_value;
    logic              r_out_valid;
    logic [SYM_W-1:0]  r_out_symbol;

    logic              out_free;
    logic              advance;
    logic              is_decipher;
    logic              is_write;
    logic              in_take;
    t_rotor_wr         wr_fast, wr_middle, wr_slow;
    t_odo_ctl          odo_ctl;
    logic [SYM_W-1:0]  pos_fast, pos_middle, pos_slow;
    logic [SYM_W-1:0]  after_slow, after_middle, after_fast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_fast   <= '0;
            r_start_middle <= '0;
            r_start_slow   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_FAST:   r_start_fast   <= i_cfg_data;
                CFG_START_MIDDLE: r_start_middle <= i_cfg_data;
                CFG_START_SLOW:   r_start_slow   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A decipher word needs room at the output; other words leave at once.
    always_comb begin
        is_decipher = (r_in_mode == MODE_DECIPHER);
        is_write    = (r_in_mode == MODE_WRITE);
        out_free    = !r_out_valid || i_m_tready;
        advance     = r_in_valid && (!is_decipher || out_free);
        o_s_tready  = !r_in_valid || advance;
        in_take     = i_s_tvalid && o_s_tready;

        wr_fast.en      = advance && is_write && (r_in_sel == ROTOR_FAST);
        wr_fast.idx     = r_in_idx;
        wr_fast.value   = r_in_value;
        wr_middle.en    = advance && is_write && (r_in_sel == ROTOR_MIDDLE);
        wr_middle.idx   = r_in_idx;
        wr_middle.value = r_in_value;
        wr_slow.en      = advance && is_write && (r_in_sel == ROTOR_SLOW);
        wr_slow.idx     = r_in_idx;
        wr_slow.value   = r_in_value;

        odo_ctl.step    = advance && is_decipher;
        odo_ctl.restart = advance && (r_in_mode == MODE_RESTART);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= advance && is_decipher;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode   <= i_s_tuser;
            r_in_symbol <= i_s_tdata[4:0];
            r_in_sel    <= i_s_tdata[6:5];
            r_in_idx    <= i_s_tdata[11:7];
            r_in_value  <= i_s_tdata[16:12];
        end
        if (out_free) begin
            r_out_symbol <= after_fast;
        end
    end

    trsd_odometer #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_odometer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (odo_ctl),
        .i_start_fast  (r_start_fast),
        .i_start_middle(r_start_middle),
        .i_start_slow  (r_start_slow),
        .o_fast        (pos_fast),
        .o_middle      (pos_middle),
        .o_slow        (pos_slow)
    );

    // The letter runs slow, then middle, then fast.
    trsd_rotor #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_rotor_slow (
        .i_clk   (i_clk),
        .i_wr    (wr_slow),
        .i_letter(r_in_symbol),
        .i_pos   (pos_slow),
        .o_letter(after_slow)
    );

    trsd_rotor #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_rotor_middle (
        .i_clk   (i_clk),
        .i_wr    (wr_middle),
        .i_letter(after_slow),
        .i_pos   (pos_middle),
        .o_letter(after_middle)
    );

    trsd_rotor #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_rotor_fast (
        .i_clk   (i_clk),
        .i_wr    (wr_fast),
        .i_letter(after_middle),
        .i_pos   (pos_fast),
        .o_letter(after_fast)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(8 - SYM_W){1'b0}}, r_out_symbol};

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_decipher) |=> r_out_valid)
        else $error("deciphered word did not reach the output register");

endmodule
